// ----- design/cfr_pkg.sv -----
`timescale 1ns / 1ps

package cfr_pkg;

	localparam int CFG_IDX_W    = 3;
	localparam int NUM_LEN_REGS = 4;
	localparam int SHOWN_BYTES  = 5;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SYNC = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEN0 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEN1 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEN2 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LEN3 = 3'd4;

	localparam logic [7:0] SYNC_RESET = 8'h21;
	localparam logic [2:0] LEN0_RESET = 3'd5;
	localparam logic [2:0] LEN1_RESET = 3'd0;
	localparam logic [2:0] LEN2_RESET = 3'd1;
	localparam logic [2:0] LEN3_RESET = 3'd0;

	typedef struct packed {
		logic [7:0]                   sync_value;
		logic [NUM_LEN_REGS-1:0][2:0] length;
	} cfg_t;

	typedef struct packed {
		logic [1:0]                  command;
		logic [2:0]                  payload_len;
		logic [SHOWN_BYTES-1:0][7:0] payload;
	} result_t;

endpackage

// ----- design/cfr_config.sv -----
`timescale 1ns / 1ps

module cfr_config (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [cfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                   cfg_data,
	output cfr_pkg::cfg_t                cfg
);
	import cfr_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_value <= SYNC_RESET;
			cfg_q.length[0]  <= LEN0_RESET;
			cfg_q.length[1]  <= LEN1_RESET;
			cfg_q.length[2]  <= LEN2_RESET;
			cfg_q.length[3]  <= LEN3_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SYNC: cfg_q.sync_value <= cfg_data;
				REG_LEN0: cfg_q.length[0]  <= cfg_data[2:0];
				REG_LEN1: cfg_q.length[1]  <= cfg_data[2:0];
				REG_LEN2: cfg_q.length[2]  <= cfg_data[2:0];
				REG_LEN3: cfg_q.length[3]  <= cfg_data[2:0];
				default: ;  // unknown index, write dropped
			endcase
		end
	end

endmodule

// ----- design/cfr_parser.sv -----
`timescale 1ns / 1ps

module cfr_parser #(
	parameter int MAX_PAYLOAD  = 5,
	parameter int NUM_COMMANDS = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfr_pkg::cfg_t    cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       rx_byte,
	input  logic             out_full,
	output logic             res_valid,
	output cfr_pkg::result_t res
);
	import cfr_pkg::*;

	localparam int         MAX_CLIP = (MAX_PAYLOAD > 7) ? 7 : MAX_PAYLOAD;
	localparam logic [2:0] MAX_LEN  = 3'(MAX_CLIP);
	localparam logic [7:0] CMD_LIMIT = 8'(NUM_COMMANDS);

	typedef enum logic [4:0] {
		PH_SYNC1 = 5'b00001,
		PH_SYNC2 = 5'b00010,
		PH_CMD   = 5'b00100,
		PH_DATA  = 5'b01000,
		PH_SUM   = 5'b10000
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [1:0] held_cmd_q, held_cmd_d;
	logic [2:0] exp_len_q, exp_len_d;
	logic [2:0] taken_q, taken_d;
	logic [7:0] sum_q, sum_d;
	logic [7:0] store_q [MAX_PAYLOAD];
	logic [SHOWN_BYTES-1:0][7:0] shown;

	logic       accept;
	logic [2:0] len_sel;
	logic [2:0] len_sat;
	logic [2:0] taken_inc;

	// only a checksum byte can produce a result, so other bytes pass a full output
	assign in_ready  = (phase_q != PH_SUM) || !out_full;
	assign accept    = in_valid && in_ready;
	assign len_sel   = cfg.length[rx_byte[1:0]];
	assign len_sat   = (len_sel > MAX_LEN) ? MAX_LEN : len_sel;
	assign taken_inc = taken_q + 3'd1;

	always_comb begin
		phase_d    = phase_q;
		held_cmd_d = held_cmd_q;
		exp_len_d  = exp_len_q;
		taken_d    = taken_q;
		sum_d      = sum_q;
		res_valid  = 1'b0;
		if (accept) begin
			unique case (phase_q)
				PH_SYNC2: phase_d = (rx_byte == cfg.sync_value) ? PH_CMD : PH_SYNC1;
				PH_CMD: begin
					if (rx_byte < CMD_LIMIT) begin
						held_cmd_d = rx_byte[1:0];
						exp_len_d  = len_sat;
						taken_d    = 3'd0;
						sum_d      = rx_byte;
						phase_d    = (len_sat == 3'd0) ? PH_SUM : PH_DATA;
					end else begin
						phase_d = PH_SYNC1;
					end
				end
				PH_DATA: begin
					sum_d   = sum_q + rx_byte;
					taken_d = taken_inc;
					if (taken_inc >= exp_len_q) begin
						phase_d = PH_SUM;
					end
				end
				PH_SUM: begin
					res_valid = (rx_byte == sum_q);
					phase_d   = PH_SYNC1;
				end
				default: phase_d = (rx_byte == cfg.sync_value) ? PH_SYNC2 : PH_SYNC1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SYNC1;
			held_cmd_q <= 2'd0;
			exp_len_q  <= 3'd0;
			taken_q    <= 3'd0;
			sum_q      <= 8'd0;
		end else begin
			phase_q    <= phase_d;
			held_cmd_q <= held_cmd_d;
			exp_len_q  <= exp_len_d;
			taken_q    <= taken_d;
			sum_q      <= sum_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_PAYLOAD; k++) begin
				store_q[k] <= 8'd0;
			end
		end else if (accept && (phase_q == PH_DATA)) begin
			for (int k = 0; k < MAX_PAYLOAD; k++) begin
				if (taken_q == 3'(k)) begin
					store_q[k] <= rx_byte;
				end
			end
		end
	end

	// bytes past the frame length read as zero
	for (genvar k = 0; k < SHOWN_BYTES; k++) begin : g_shown
		if (k < MAX_PAYLOAD) begin : g_real
			assign shown[k] = (3'(k) < exp_len_q) ? store_q[k] : 8'd0;
		end else begin : g_none
			assign shown[k] = 8'd0;
		end
	end

	assign res.command     = held_cmd_q;
	assign res.payload_len = exp_len_q;
	assign res.payload     = shown;

endmodule

// ----- design/cfr_out_reg.sv -----
`timescale 1ns / 1ps

module cfr_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  cfr_pkg::result_t res_in,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             out_full,
	output cfr_pkg::result_t res_out
);
	import cfr_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign out_valid = valid_q;
	assign out_full  = valid_q && !out_ready;
	assign res_out   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

// ----- design/command_frame_receiver_core.sv -----
`timescale 1ns / 1ps

// framed command receiver
// in channel (in_valid/in_ready, rx_byte) takes one received byte per transaction.
// a frame is sync, sync, command, that command's payload bytes, checksum; the
// checksum is command plus payload modulo 256. a good frame gives one transaction
// on the out channel (command, payload_len, payload_b0..payload_b4, unused bytes
// zero); a bad sync, command or checksum drops the frame without a result.
// cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes sync_value (0)
// and the per-command lengths (1..4); cfg_ready is always high, write only when idle.
// throughput: one byte per cycle, but a checksum byte stalls while the output is full.
// latency: the result is registered and shows on out_valid the cycle after
// the checksum byte is taken.
// when the output is held by out_ready low, bytes keep being accepted except a
// checksum byte, which waits until the output register frees up.
// reset: all registers but the result data return to defaults; parser hunts for sync.
module command_frame_receiver_core #(
	parameter int MAX_PAYLOAD  = 5,
	parameter int NUM_COMMANDS = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [cfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    rx_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    command,
	output logic [2:0]                    payload_len,
	output logic [7:0]                    payload_b0,
	output logic [7:0]                    payload_b1,
	output logic [7:0]                    payload_b2,
	output logic [7:0]                    payload_b3,
	output logic [7:0]                    payload_b4
);
	import cfr_pkg::*;

	cfg_t    cfg;
	result_t res;
	result_t res_out;
	logic    res_valid;
	logic    out_full;

	cfr_config u_config (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cfr_parser #(
		.MAX_PAYLOAD  (MAX_PAYLOAD),
		.NUM_COMMANDS (NUM_COMMANDS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.out_full  (out_full),
		.res_valid (res_valid),
		.res       (res)
	);

	cfr_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_valid),
		.res_in    (res),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_full  (out_full),
		.res_out   (res_out)
	);

	assign command     = res_out.command;
	assign payload_len = res_out.payload_len;
	assign payload_b0  = res_out.payload[0];
	assign payload_b1  = res_out.payload[1];
	assign payload_b2  = res_out.payload[2];
	assign payload_b3  = res_out.payload[3];
	assign payload_b4  = res_out.payload[4];

endmodule

// ----- design/cfr_checker.sv -----
`timescale 1ns / 1ps

module cfr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] command,
	input logic [2:0] payload_len,
	input logic [7:0] payload_b0,
	input logic [7:0] payload_b1,
	input logic [7:0] payload_b2,
	input logic [7:0] payload_b3,
	input logic [7:0] payload_b4
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped before the transaction completed");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(command) && $stable(payload_len)
			&& $stable(payload_b0) && $stable(payload_b1) && $stable(payload_b2)
			&& $stable(payload_b3) && $stable(payload_b4))
		else $error("result changed while stalled");

	// a new result only follows an accepted byte
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("result without a preceding byte");

	a_empty_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (payload_len == 3'd0) |-> (payload_b0 == 8'd0))
		else $error("zero-length frame shows payload data");

endmodule

bind command_frame_receiver_core cfr_checker u_cfr_checker (.*);
